FILE: src/x86_alu_with_flags_core_macros.svh
// ----------------------------------------------------------------------------
// x86 alu assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef X86_ALU_WITH_FLAGS_CORE_MACROS_SVH
`define X86_ALU_WITH_FLAGS_CORE_MACROS_SVH

// same-cycle implication
`define X86ALU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("x86alu assertion failed");

// next-cycle implication
`define X86ALU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("x86alu assertion failed");

`endif

FILE: src/x86alu_pkg.sv
// ----------------------------------------------------------------------------
// x86alu_pkg
// Request and result types and operation and size codes for the x86 alu.
// ----------------------------------------------------------------------------
package x86alu_pkg;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_SUB = 2'd1;
  localparam logic [1:0] FUNC_XOR = 2'd2;
  localparam logic [1:0] FUNC_SHL = 2'd3;

  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;
  localparam logic [1:0] SIZE_64 = 2'd3;

  // auxiliary carry is bit 4 of a ^ b ^ result
  localparam logic [63:0] AUX_MASK = 64'h10;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  size_code;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
  } req_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        carry_flag;
    logic        parity_flag;
    logic        aux_flag;
    logic        zero_flag;
    logic        sign_flag;
    logic        overflow_flag;
    logic        flags_written;
    logic        overflow_written;
  } rsp_t;

endpackage

FILE: src/x86_alu_with_flags_core.sv
// ----------------------------------------------------------------------------
// x86_alu_with_flags_core
// Sized add, subtract, xor and shift left with x86 status flags.
// ----------------------------------------------------------------------------
// A request (func, size_code, operand_a, operand_b) is taken at a rising edge
// with start high and busy low. busy is only high while rst is asserted, so a
// new request can be taken every cycle.
// Three register stages: operand sizing and shift count, then the adder,
// subtractor and shifter with carry, aux and overflow, then zero, sign and
// parity into the result register. done is high for one cycle, once the request
// has passed s1_valid and s2_valid, with the result on result; it must be taken then.
// Throughput is one request per cycle, and no state is kept between requests.
// A synchronous reset clears the stage valid bits, so requests in flight
// are dropped and done stays low until new requests arrive.
// ----------------------------------------------------------------------------
module x86_alu_with_flags_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  x86alu_pkg::req_t  request,
  output logic              done,
  output x86alu_pkg::rsp_t  result
);

  function automatic logic msb_of(input logic [1:0] size, input logic [63:0] v);
    logic m;
    case (size)
      x86alu_pkg::SIZE_8:  m = v[7];
      x86alu_pkg::SIZE_16: m = v[15];
      x86alu_pkg::SIZE_32: m = v[31];
      default:             m = v[63];
    endcase
    return m;
  endfunction

  logic accept;
  assign busy   = rst;
  assign accept = start && !busy;

  // ---------------- stage 1: size the operands ----------------
  logic [63:0] in_mask;
  logic [6:0]  in_bits;
  logic [5:0]  in_cnt;

  always_comb begin
    case (request.size_code)
      x86alu_pkg::SIZE_8: begin
        in_mask = 64'h0000_0000_0000_00FF;
        in_bits = 7'd8;
      end
      x86alu_pkg::SIZE_16: begin
        in_mask = 64'h0000_0000_0000_FFFF;
        in_bits = 7'd16;
      end
      x86alu_pkg::SIZE_32: begin
        in_mask = 64'h0000_0000_FFFF_FFFF;
        in_bits = 7'd32;
      end
      default: begin
        in_mask = 64'hFFFF_FFFF_FFFF_FFFF;
        in_bits = 7'd64;
      end
    endcase
    in_cnt = (request.size_code == x86alu_pkg::SIZE_64) ?
             request.operand_b[5:0] : {1'b0, request.operand_b[4:0]};
  end

  logic        s1_valid;
  logic [1:0]  s1_func;
  logic [1:0]  s1_size;
  logic [63:0] s1_a;
  logic [63:0] s1_b;
  logic [63:0] s1_mask;
  logic [6:0]  s1_bits;
  logic [5:0]  s1_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_func <= request.func;
    s1_size <= request.size_code;
    s1_a    <= request.operand_a & in_mask;
    s1_b    <= request.operand_b & in_mask;
    s1_mask <= in_mask;
    s1_bits <= in_bits;
    s1_cnt  <= in_cnt;
  end

  // ---------------- stage 2: arithmetic and shifter ----------------
  logic [64:0] sum;
  logic [64:0] diff;
  logic [63:0] add_res;
  logic [63:0] sub_res;
  logic [63:0] shl_res;
  logic [6:0]  sh_pos;
  logic        msb_a;
  logic        msb_b;
  logic        shl_cf;
  logic [63:0] res_next;
  logic        cf_next;
  logic        af_next;
  logic        of_next;
  logic        fw_next;
  logic        ow_next;

  always_comb begin
    sum     = {1'b0, s1_a} + {1'b0, s1_b};
    diff    = {1'b0, s1_a} - {1'b0, s1_b};
    add_res = sum[63:0] & s1_mask;
    sub_res = diff[63:0] & s1_mask;
    shl_res = (s1_a << s1_cnt) & s1_mask;
    msb_a   = msb_of(s1_size, s1_a);
    msb_b   = msb_of(s1_size, s1_b);
    // last bit out sits at position size - count; nothing left past the size
    sh_pos  = s1_bits - {1'b0, s1_cnt};
    shl_cf  = ({1'b0, s1_cnt} <= s1_bits) ? s1_a[sh_pos[5:0]] : 1'b0;

    res_next = s1_a ^ s1_b;
    cf_next  = 1'b0;
    af_next  = 1'b0;
    of_next  = 1'b0;
    fw_next  = 1'b1;
    ow_next  = 1'b1;
    case (s1_func)
      x86alu_pkg::FUNC_ADD: begin
        res_next = add_res;
        cf_next  = sum[s1_bits];
        af_next  = |((s1_a ^ s1_b ^ add_res) & x86alu_pkg::AUX_MASK);
        of_next  = ~(msb_a ^ msb_b) & (msb_a ^ msb_of(s1_size, add_res));
      end
      x86alu_pkg::FUNC_SUB: begin
        res_next = sub_res;
        cf_next  = diff[64];
        af_next  = |((s1_a ^ s1_b ^ sub_res) & x86alu_pkg::AUX_MASK);
        of_next  = (msb_a ^ msb_b) & (msb_a ^ msb_of(s1_size, sub_res));
      end
      x86alu_pkg::FUNC_XOR: begin
        res_next = s1_a ^ s1_b;
      end
      default: begin
        if (s1_cnt == 6'd0) begin
          // shift by zero leaves a and writes no flags
          res_next = s1_a;
          fw_next  = 1'b0;
          ow_next  = 1'b0;
        end else begin
          res_next = shl_res;
          cf_next  = shl_cf;
          if (s1_cnt == 6'd1) begin
            of_next = msb_of(s1_size, shl_res) ^ shl_cf;
          end else begin
            ow_next = 1'b0;
          end
        end
      end
    endcase
  end

  logic        s2_valid;
  logic [1:0]  s2_size;
  logic [63:0] s2_res;
  logic        s2_cf;
  logic        s2_af;
  logic        s2_of;
  logic        s2_fw;
  logic        s2_ow;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_size <= s1_size;
    s2_res  <= res_next;
    s2_cf   <= cf_next;
    s2_af   <= af_next;
    s2_of   <= of_next;
    s2_fw   <= fw_next;
    s2_ow   <= ow_next;
  end

  // ---------------- stage 3: result flags ----------------
  x86alu_pkg::rsp_t rsp_next;

  always_comb begin
    rsp_next.result_value     = s2_res;
    rsp_next.carry_flag       = s2_fw & s2_cf;
    rsp_next.parity_flag      = s2_fw & ~(^s2_res[7:0]);
    rsp_next.aux_flag         = s2_fw & s2_af;
    rsp_next.zero_flag        = s2_fw & (s2_res == 64'd0);
    rsp_next.sign_flag        = s2_fw & msb_of(s2_size, s2_res);
    rsp_next.overflow_flag    = s2_ow & s2_of;
    rsp_next.flags_written    = s2_fw;
    rsp_next.overflow_written = s2_ow;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
    result <= rsp_next;
  end

endmodule

FILE: src/x86alu_checker.sv
// ----------------------------------------------------------------------------
// x86alu_checker
// Port-level checks on request-to-result timing and flag consistency.
// ----------------------------------------------------------------------------
`include "x86_alu_with_flags_core_macros.svh"

module x86alu_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input x86alu_pkg::rsp_t result
);

  logic fw_off_clean;
  logic zero_ok;

  assign fw_off_clean = !result.carry_flag && !result.parity_flag && !result.aux_flag &&
                        !result.zero_flag && !result.sign_flag && !result.overflow_written;
  assign zero_ok      = (result.result_value == 64'd0);

  // every accepted request gives exactly one done result, and each done has an accepted request
  `X86ALU_ASSERT_NXT(a_req_to_done, start && !busy, ##2 done)
  `X86ALU_ASSERT_IMP(a_done_from_req, done, $past(start && !busy, 3))
  // unwritten flags read as zero
  `X86ALU_ASSERT_IMP(a_fw_off, done && !result.flags_written, fw_off_clean)
  `X86ALU_ASSERT_IMP(a_ow_off, done && !result.overflow_written, !result.overflow_flag)
  `X86ALU_ASSERT_IMP(a_zero, done && result.zero_flag, zero_ok)

endmodule

bind x86_alu_with_flags_core x86alu_checker u_x86alu_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .result  (result)
);

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// x86 alu flags testbench
// A driver sends sized add, subtract, xor and shift left requests, starting
// with boundary cases and going on to random operands. Each accepted request
// is run through a local flag predictor. A monitor compares every result
// field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CYCLE_LIMIT    = 50000;
  localparam int unsigned RANDOM_ITEMS   = 550;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned RESET_CYCLES   = 6;
  localparam int unsigned IDLE_LIGHT     = 17;
  localparam int unsigned IDLE_HEAVY     = 60;
  localparam int unsigned PHASE_LEN      = 192;
  localparam logic [63:0] COUNT_MASK_32  = 64'h1f;
  localparam logic [63:0] COUNT_MASK_64  = 64'h3f;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  x86alu_pkg::req_t request = '0;
  x86alu_pkg::rsp_t result;

  x86alu_pkg::req_t pending_q[$];
  x86alu_pkg::rsp_t predicted_q[$];
  int unsigned accepted_count = 0;
  int unsigned checked_count = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned func_count[4] = '{0, 0, 0, 0};

  x86_alu_with_flags_core dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic int unsigned width_of(logic [1:0] code);
    case (code)
      x86alu_pkg::SIZE_8:  return 8;
      x86alu_pkg::SIZE_16: return 16;
      x86alu_pkg::SIZE_32: return 32;
      default: return 64;
    endcase
  endfunction

  function automatic logic [63:0] mask_of(int unsigned bits);
    return (bits == 64) ? {64{1'b1}} : ((64'd1 << bits) - 64'd1);
  endfunction

  function automatic x86alu_pkg::rsp_t alu_flags_predict(x86alu_pkg::req_t r);
    int unsigned bits;
    int unsigned cnt;
    logic [63:0] mask;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] top;
    logic [63:0] res;
    logic cf;
    logic af;
    logic of;
    logic fw;
    logic ow;
    x86alu_pkg::rsp_t p;
    bits = width_of(r.size_code);
    mask = mask_of(bits);
    a = r.operand_a & mask;
    b = r.operand_b & mask;
    top = 64'd1 << (bits - 1);
    res = '0;
    cf = 1'b0;
    af = 1'b0;
    of = 1'b0;
    fw = 1'b1;
    ow = 1'b1;
    case (r.func)
      x86alu_pkg::FUNC_ADD: begin
        res = (a + b) & mask;
        cf = res < a;
        af = ((a ^ b ^ res) & x86alu_pkg::AUX_MASK) != 0;
        of = (((a ^ b) & top) == 0) && (((a ^ res) & top) != 0);
      end
      x86alu_pkg::FUNC_SUB: begin
        res = (a - b) & mask;
        cf = a < b;
        af = ((a ^ b ^ res) & x86alu_pkg::AUX_MASK) != 0;
        of = (((a ^ b) & top) != 0) && (((a ^ res) & top) != 0);
      end
      x86alu_pkg::FUNC_XOR: begin
        res = a ^ b;
      end
      default: begin
        cnt = int'(r.operand_b & ((bits == 64) ? COUNT_MASK_64 : COUNT_MASK_32));
        if (cnt == 0) begin
          res = a;
          fw = 1'b0;
          ow = 1'b0;
        end else begin
          res = (a << cnt) & mask;
          // bits shifted past the operand size carry nothing out
          cf = (cnt <= bits) ? (((a >> (bits - cnt)) & 64'd1) != 0) : 1'b0;
          if (cnt == 1) of = ((res & top) != 0) ^ cf;
          else ow = 1'b0;
        end
      end
    endcase
    p.result_value     = res;
    p.carry_flag       = fw & cf;
    p.parity_flag      = fw & ~(^res[7:0]);
    p.aux_flag         = fw & af;
    p.zero_flag        = fw & (res == 0);
    p.sign_flag        = fw & ((res & top) != 0);
    p.overflow_flag    = ow & of;
    p.flags_written    = fw;
    p.overflow_written = ow;
    return p;
  endfunction

  function automatic logic [63:0] pick_operand(logic [1:0] size_code);
    int unsigned bits;
    logic [63:0] mask;
    logic [63:0] v;
    bits = width_of(size_code);
    mask = mask_of(bits);
    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: v = '0;
      2: v = {64{1'b1}};
      // values around the sign boundary reach overflow at every size
      3: v = (64'd1 << (bits - 1)) + 64'($urandom_range(0, 4)) - 64'd2;
      4: v = 64'($urandom_range(0, 20));
      default: v = mask - 64'($urandom_range(0, 20));
    endcase
    if ($urandom_range(0, 1) == 1) v = (v & mask) | (~mask & {$urandom, $urandom});
    return v;
  endfunction

  function automatic x86alu_pkg::req_t random_request();
    x86alu_pkg::req_t r;
    int unsigned cnt;
    r.func = 2'($urandom_range(0, 3));
    r.size_code = 2'($urandom_range(0, 3));
    r.operand_a = pick_operand(r.size_code);
    r.operand_b = pick_operand(r.size_code);
    if (r.func == x86alu_pkg::FUNC_SHL) begin
      // favor zero, one and counts near the operand size
      case ($urandom_range(0, 3))
        0: cnt = $urandom_range(0, 1);
        1: cnt = width_of(r.size_code) - $urandom_range(0, 2);
        default: cnt = $urandom_range(0, 63);
      endcase
      r.operand_b[5:0] = 6'(cnt);
    end
    return r;
  endfunction

  task automatic queue_request(logic [1:0] f, logic [1:0] s, logic [63:0] a,
                               logic [63:0] b);
    x86alu_pkg::req_t r;
    r.func = f;
    r.size_code = s;
    r.operand_a = a;
    r.operand_b = b;
    pending_q.push_back(r);
  endtask

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: mismatch on %s, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  function automatic int unsigned idle_percent(int unsigned n);
    if (n < PHASE_LEN) return IDLE_LIGHT;
    if (n < 2 * PHASE_LEN) return IDLE_HEAVY;
    return 0;
  endfunction

  // driver: a request stays on the ports until it is taken
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predicted_q.push_back(alu_flags_predict(request));
        func_count[request.func]++;
        accepted_count++;
      end
      if (!(start && busy)) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= idle_percent(accepted_count)) begin
          request <= pending_q.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: results cannot be held off, each done cycle is one result
  always @(posedge clk) begin
    x86alu_pkg::rsp_t want;
    if (!rst && done) begin
      if (predicted_q.size() == 0) begin
        $display("%0t: result with nothing predicted, actual %h", $time, result);
        error_count++;
      end else begin
        want = predicted_q.pop_front();
        checked_count++;
        compare_field("result_value", want.result_value, result.result_value);
        compare_field("carry_flag", 64'(want.carry_flag), 64'(result.carry_flag));
        compare_field("parity_flag", 64'(want.parity_flag), 64'(result.parity_flag));
        compare_field("aux_flag", 64'(want.aux_flag), 64'(result.aux_flag));
        compare_field("zero_flag", 64'(want.zero_flag), 64'(result.zero_flag));
        compare_field("sign_flag", 64'(want.sign_flag), 64'(result.sign_flag));
        compare_field("overflow_flag", 64'(want.overflow_flag), 64'(result.overflow_flag));
        compare_field("flags_written", 64'(want.flags_written), 64'(result.flags_written));
        compare_field("overflow_written", 64'(want.overflow_written),
                      64'(result.overflow_written));
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("x86_alu_with_flags_core verification failed");
    $finish;
  end

  initial begin
    // carries, overflow and zero at the size boundaries
    queue_request(x86alu_pkg::FUNC_ADD, x86alu_pkg::SIZE_8, 64'hff, 64'h01);
    queue_request(x86alu_pkg::FUNC_ADD, x86alu_pkg::SIZE_8, 64'h7f, 64'h01);
    queue_request(x86alu_pkg::FUNC_ADD, x86alu_pkg::SIZE_64, {64{1'b1}}, 64'h1);
    queue_request(x86alu_pkg::FUNC_ADD, x86alu_pkg::SIZE_64, 64'h7fff_ffff_ffff_ffff, 64'h1);
    queue_request(x86alu_pkg::FUNC_ADD, x86alu_pkg::SIZE_16, 64'hffff_ffff_ffff_8000,
                  64'haaaa_5555_0000_8000);
    queue_request(x86alu_pkg::FUNC_ADD, x86alu_pkg::SIZE_32, 64'h0, 64'h0);
    queue_request(x86alu_pkg::FUNC_SUB, x86alu_pkg::SIZE_8, 64'h00, 64'h01);
    queue_request(x86alu_pkg::FUNC_SUB, x86alu_pkg::SIZE_8, 64'h80, 64'h01);
    queue_request(x86alu_pkg::FUNC_SUB, x86alu_pkg::SIZE_64, 64'h0, 64'h1);
    queue_request(x86alu_pkg::FUNC_SUB, x86alu_pkg::SIZE_32, 64'h8000_0000, 64'h1);
    queue_request(x86alu_pkg::FUNC_SUB, x86alu_pkg::SIZE_16, 64'h1234_0000_0000_abcd,
                  64'h0000_abcd);
    queue_request(x86alu_pkg::FUNC_XOR, x86alu_pkg::SIZE_64, {64{1'b1}},
                  64'h5555_5555_5555_5555);
    queue_request(x86alu_pkg::FUNC_XOR, x86alu_pkg::SIZE_8, 64'h3c, 64'hff00_003c);
    queue_request(x86alu_pkg::FUNC_XOR, x86alu_pkg::SIZE_32, 64'hdead_beef_8000_0001,
                  64'h0000_0001);
    // shift by zero after masking the count
    queue_request(x86alu_pkg::FUNC_SHL, x86alu_pkg::SIZE_8, 64'h5a, 64'h20);
    queue_request(x86alu_pkg::FUNC_SHL, x86alu_pkg::SIZE_64, 64'h8000_0000_0000_0001, 64'h40);
    // shift by one writes overflow
    queue_request(x86alu_pkg::FUNC_SHL, x86alu_pkg::SIZE_8, 64'h40, 64'h1);
    queue_request(x86alu_pkg::FUNC_SHL, x86alu_pkg::SIZE_16, 64'h8000, 64'h1);
    // counts at and beyond the narrow operand sizes
    queue_request(x86alu_pkg::FUNC_SHL, x86alu_pkg::SIZE_8, 64'h01, 64'h8);
    queue_request(x86alu_pkg::FUNC_SHL, x86alu_pkg::SIZE_8, 64'hff, 64'h9);
    queue_request(x86alu_pkg::FUNC_SHL, x86alu_pkg::SIZE_16, 64'hffff, 64'h1f);
    queue_request(x86alu_pkg::FUNC_SHL, x86alu_pkg::SIZE_16, 64'h0001, 64'h10);
    queue_request(x86alu_pkg::FUNC_SHL, x86alu_pkg::SIZE_32, 64'h1, 64'h1f);
    queue_request(x86alu_pkg::FUNC_SHL, x86alu_pkg::SIZE_64, 64'h3, 64'h3f);
    queue_request(x86alu_pkg::FUNC_SHL, x86alu_pkg::SIZE_64, {64{1'b1}}, 64'h1);
    for (int i = 0; i < RANDOM_ITEMS; i++) pending_q.push_back(random_request());

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    wait (pending_q.size() == 0 && !start);
    wait (predicted_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results from %0d requests over all four operand sizes",
             checked_count, accepted_count);
    $display("add %0d, sub %0d, xor %0d, shl %0d, errors %0d",
             func_count[x86alu_pkg::FUNC_ADD], func_count[x86alu_pkg::FUNC_SUB],
             func_count[x86alu_pkg::FUNC_XOR], func_count[x86alu_pkg::FUNC_SHL],
             error_count);
    if (error_count == 0 && predicted_q.size() == 0) begin
      $display("x86_alu_with_flags_core verification clean");
    end else begin
      $display("x86_alu_with_flags_core verification failed");
    end
    $finish;
  end

endmodule
